@@ hw/rtl/bia_pkg.sv @@
// Shared constants for the bitmap handle allocator.
// Operation codes, configuration register indexes and stream word widths.
// No dependencies.
package bia_pkg;

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_INIT  = 2'd2;

  localparam logic REG_TOP_MASK  = 1'b0;
  localparam logic REG_RSV_COUNT = 1'b1;

  localparam int MAP_WORD_W = 64;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_DATA_W = 32;

endpackage

@@ hw/rtl/bitmap_id_allocator.sv @@
// Bitmap handle allocator: allocate, free and init over a map of SLOTS entries; uses bia_pkg.
// Sequence: free, init and unknown operations go to ST_FIN, which registers the result word;
// allocate scans one 64-entry map word per cycle in ST_SCAN from the search start word, wrapping once.
// A new operation is accepted only in ST_IDLE, so a stalled result holds the next operation.
// Reset (synchronous, active low) clears the map, search start and tag at once.
module bitmap_id_allocator #(
  parameter int SLOTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // fields from bit 0: func[1:0], handle_in[33:2], zero fill
  input  logic [bia_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // fields from bit 0: handle_out[31:0], ok[32], zero fill
  output logic [bia_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [bia_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int WW   = bia_pkg::MAP_WORD_W;
  localparam int NW   = (SLOTS + WW - 1) / WW;
  localparam int WIW  = (NW > 1) ? $clog2(NW) : 1;
  localparam int IW   = $clog2(SLOTS);
  localparam int PW1  = $clog2(NW * WW) + 1;
  localparam logic [WIW-1:0] LAST_WORD = WIW'(NW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  state_t            state_r;
  logic [1:0]        func_r;
  logic [31:0]       handle_r;
  logic [WIW-1:0]    word_r;
  logic              pass_r;
  logic [SLOTS-1:0]  map_r;
  logic [IW-1:0]     start_r;
  logic [31:0]       tag_r;
  logic [31:0]       top_mask_r;
  logic [6:0]        rsv_count_r;
  logic              out_tvalid_r;
  logic [31:0]       out_handle_r;
  logic              out_ok_r;

  logic [NW*WW-1:0]  map_pad;
  logic [WW-1:0]     cur_word;
  logic [PW1-1:0]    base;
  logic [PW1-1:0]    gi;
  logic [WW-1:0]     cand;
  logic              hit;
  logic [5:0]        hit_j;
  logic [PW1-1:0]    hit_gi;
  logic [IW-1:0]     hit_idx;
  logic [31:0]       tag_adv;
  logic [31:0]       free_idx;
  logic [SLOTS-1:0]  init_map;
  logic [WIW-1:0]    start_word;
  logic              out_free;
  logic              out_load;

  always_comb begin
    for (int k = 0; k < NW * WW; k++) begin
      if (k < SLOTS) map_pad[k] = map_r[k];
      else           map_pad[k] = 1'b1;
    end
  end

  assign cur_word = map_pad[word_r*WW +: WW];
  assign base     = PW1'(word_r) << 6;

  always_comb begin
    gi = '0;
    for (int j = 0; j < WW; j++) begin
      gi      = base + PW1'(j);
      cand[j] = !cur_word[j] && (pass_r || (gi >= PW1'(start_r)));
    end
  end

  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = WW - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit   = 1'b1;
        hit_j = 6'(j);
      end
    end
  end

  assign hit_gi     = base + PW1'(hit_j);
  assign hit_idx    = hit_gi[IW-1:0];
  assign tag_adv    = (tag_r + 32'(SLOTS)) & top_mask_r;
  assign free_idx   = handle_r & 32'(SLOTS - 1);
  assign start_word = WIW'(start_r >> 6);
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_load   = out_free && ((state_r == ST_FIN) ||
                      ((state_r == ST_SCAN) && (hit || ((word_r == LAST_WORD) && pass_r))));

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      init_map[i] = (32'(i) < 32'(rsv_count_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      map_r        <= '0;
      start_r      <= '0;
      tag_r        <= '0;
      top_mask_r   <= 32'hFFFF_FFFF;
      rsv_count_r  <= '0;
      out_tvalid_r <= 1'b0;
      pass_r       <= 1'b0;
      word_r       <= '0;
    end else begin
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_index)
          bia_pkg::REG_TOP_MASK:  top_mask_r  <= cfg_data;
          bia_pkg::REG_RSV_COUNT: rsv_count_r <= cfg_data[6:0];
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            func_r   <= in_tdata[1:0];
            handle_r <= in_tdata[33:2];
            word_r   <= start_word;
            pass_r   <= 1'b0;
            state_r  <= (in_tdata[1:0] == bia_pkg::FN_ALLOC) ? ST_SCAN : ST_FIN;
          end
        end
        ST_SCAN: begin
          if (hit) begin
            if (out_free) begin
              map_r[hit_idx] <= 1'b1;
              out_handle_r   <= 32'(hit_gi) | tag_r;
              out_ok_r       <= 1'b1;
              state_r        <= ST_IDLE;
            end
          end else if (word_r == LAST_WORD) begin
            if (!pass_r) begin
              tag_r  <= tag_adv;
              pass_r <= 1'b1;
              word_r <= '0;
            end else if (out_free) begin
              out_handle_r <= '0;
              out_ok_r     <= 1'b0;
              state_r      <= ST_IDLE;
            end
          end else begin
            word_r <= word_r + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_handle_r <= '0;
            state_r      <= ST_IDLE;
            priority case (func_r)
              bia_pkg::FN_FREE: begin
                if (free_idx < 32'(SLOTS)) map_r[free_idx[IW-1:0]] <= 1'b0;
                if (free_idx < 32'(start_r)) start_r <= free_idx[IW-1:0];
                tag_r    <= tag_adv;
                out_ok_r <= 1'b1;
              end
              bia_pkg::FN_INIT: begin
                map_r    <= init_map;
                start_r  <= '0;
                tag_r    <= '0;
                out_ok_r <= 1'b1;
              end
              default: out_ok_r <= 1'b0;
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'b0, out_ok_r, out_handle_r};

endmodule
